// File: sv/tdpg_pkg.sv
// Shared constants and codes for the triggered delay pulse generator.
`default_nettype none
package tdpg_pkg;

  localparam int TICKS_PER_US_DEF = 125;
  localparam int MIN_WIDTH_US_DEF = 1;
  localparam int MAX_WIDTH_US_DEF = 50;

  localparam int MODE_W         = 2;
  localparam int TRIG_MODE_W    = 2;
  localparam int DELAY_US_W     = 20;
  localparam int WIDTH_US_W     = 8;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 20;
  localparam int WIDTH_US_RESET = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_US     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_US     = 2'd2;

  localparam logic [MODE_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] CMD_START = 2'd1;
  localparam logic [MODE_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [TRIG_MODE_W-1:0] TRIG_IMMEDIATE = 2'd0;
  localparam logic [TRIG_MODE_W-1:0] TRIG_RISING    = 2'd1;
  localparam logic [TRIG_MODE_W-1:0] TRIG_FALLING   = 2'd2;
  localparam logic [TRIG_MODE_W-1:0] TRIG_PULSE     = 2'd3;

endpackage
`default_nettype wire

// File: sv/tdpg_in_if.sv
// Input channel: one tick with its command and sampled trigger level.
`default_nettype none
interface tdpg_in_if
  import tdpg_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic              trigger_level;

  modport source (output valid, output mode, output trigger_level, input ready);
  modport sink   (input valid, input mode, input trigger_level, output ready);
endinterface
`default_nettype wire

// File: sv/tdpg_out_if.sv
// Output channel: pin and status levels after each tick.
`default_nettype none
interface tdpg_out_if;
  logic valid;
  logic ready;
  logic pulse_out;
  logic done_res;
  logic busy_res;
  logic start_rejected;

  modport source (output valid, output pulse_out, output done_res, output busy_res,
                  output start_rejected, input ready);
  modport sink   (input valid, input pulse_out, input done_res, input busy_res,
                  input start_rejected, output ready);
endinterface
`default_nettype wire

// File: sv/tdpg_cfg.sv
// Configuration registers; tick counts are scaled at write time.
`default_nettype none
module tdpg_cfg
  import tdpg_pkg::*;
#(
  parameter int TICKS_PER_US = TICKS_PER_US_DEF,
  parameter int MIN_WIDTH_US = MIN_WIDTH_US_DEF,
  parameter int MAX_WIDTH_US = MAX_WIDTH_US_DEF,
  parameter int DLY_W        = 27,
  parameter int WID_W        = 15
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [TRIG_MODE_W-1:0]      trigger_mode,
  output logic [DLY_W-1:0]            lag_ticks,
  output logic [WID_W-1:0]            width_ticks,
  output logic                        width_ok
);

  localparam logic [DLY_W-1:0] TPU_D = DLY_W'(TICKS_PER_US);
  localparam logic [WID_W-1:0] TPU_W = WID_W'(TICKS_PER_US);
  localparam logic [WIDTH_US_W-1:0] MIN_W = WIDTH_US_W'(MIN_WIDTH_US);
  localparam logic [WIDTH_US_W-1:0] MAX_W = WIDTH_US_W'(MAX_WIDTH_US);
  localparam logic RST_OK = (WIDTH_US_RESET >= MIN_WIDTH_US) &&
                            (WIDTH_US_RESET <= MAX_WIDTH_US);

  logic [WIDTH_US_W-1:0] wus;
  logic [DLY_W-1:0]      delay_prod;
  logic [WID_W-1:0]      width_prod;

  assign wus        = cfg_data[WIDTH_US_W-1:0];
  assign delay_prod = DLY_W'(DLY_W'(cfg_data[DELAY_US_W-1:0]) * TPU_D);
  assign width_prod = WID_W'(WID_W'(wus) * TPU_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_mode <= TRIG_IMMEDIATE;
      lag_ticks    <= '0;
      width_ticks  <= TPU_W;
      width_ok     <= RST_OK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIGGER_MODE: trigger_mode <= cfg_data[TRIG_MODE_W-1:0];
        REG_DELAY_US:     lag_ticks    <= delay_prod;
        REG_WIDTH_US: begin
          width_ticks <= width_prod;
          width_ok    <= (wus >= MIN_W) && (wus <= MAX_W);
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/triggered_delay_pulse_generator_core.sv
// Top level of the triggered delay pulse generator.
// One transaction per clock cycle: each accepted tick is applied to the
// sequencer state in that same cycle and its result (pulse level, done,
// busy, start rejected) sits in the output register from the next cycle.
// The output register frees itself while the sink takes the result, so
// ticks flow back to back; the only stall is a held result. The delay and
// width multiplications by TICKS_PER_US are done when the registers are
// written, so the per-tick path is a counter decrement and compare.
`default_nettype none
module triggered_delay_pulse_generator_core
  import tdpg_pkg::*;
#(
  parameter int TICKS_PER_US = TICKS_PER_US_DEF,
  parameter int MIN_WIDTH_US = MIN_WIDTH_US_DEF,
  parameter int MAX_WIDTH_US = MAX_WIDTH_US_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  tdpg_in_if.sink                     items,
  tdpg_out_if.source                  results
);

  localparam int DLY_W = $clog2(((2 ** DELAY_US_W) - 1) * TICKS_PER_US + 1);
  localparam int WID_W = $clog2(((2 ** WIDTH_US_W) - 1) * TICKS_PER_US + 2);
  localparam int CNT_W = (DLY_W > WID_W) ? DLY_W : WID_W;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_R0    = 4'd1;
  localparam logic [3:0] PH_R1    = 4'd2;
  localparam logic [3:0] PH_F1    = 4'd3;
  localparam logic [3:0] PH_F0    = 4'd4;
  localparam logic [3:0] PH_P0A   = 4'd5;
  localparam logic [3:0] PH_P1    = 4'd6;
  localparam logic [3:0] PH_P0B   = 4'd7;
  localparam logic [3:0] PH_DELAY = 4'd8;
  localparam logic [3:0] PH_HIGH  = 4'd9;

  logic [TRIG_MODE_W-1:0] cfg_trigger_mode;
  logic [DLY_W-1:0]       cfg_lag_ticks;
  logic [WID_W-1:0]       cfg_width_ticks;
  logic                   cfg_width_ok;

  tdpg_cfg #(
    .TICKS_PER_US (TICKS_PER_US),
    .MIN_WIDTH_US (MIN_WIDTH_US),
    .MAX_WIDTH_US (MAX_WIDTH_US),
    .DLY_W        (DLY_W),
    .WID_W        (WID_W)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .trigger_mode (cfg_trigger_mode),
    .lag_ticks    (cfg_lag_ticks),
    .width_ticks  (cfg_width_ticks),
    .width_ok     (cfg_width_ok)
  );

  logic [3:0]       phase, phase_next;
  logic [CNT_W-1:0] tick_count, tick_count_next;
  logic [DLY_W-1:0] lag_ticks, lag_ticks_next;
  logic [WID_W-1:0] width_ticks, width_ticks_next;
  logic             done_flag, done_flag_next;
  logic             pulse_level, pulse_level_next;
  logic             rejected;
  logic             out_valid;
  logic             accept;
  logic             lvl;

  assign items.ready = !out_valid || results.ready;
  assign accept      = items.valid && items.ready;
  assign lvl         = items.trigger_level;

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    lag_ticks_next   = lag_ticks;
    width_ticks_next = width_ticks;
    done_flag_next   = done_flag;
    pulse_level_next = pulse_level;
    rejected         = 1'b0;
    case (items.mode)
      CMD_START: begin
        if (!cfg_width_ok) begin
          rejected = 1'b1;
        end else begin
          lag_ticks_next   = cfg_lag_ticks;
          width_ticks_next = cfg_width_ticks;
          done_flag_next   = 1'b0;
          pulse_level_next = 1'b0;
          tick_count_next  = '0;
          unique case (cfg_trigger_mode)
            TRIG_IMMEDIATE: begin
              phase_next      = PH_DELAY;
              tick_count_next = CNT_W'(cfg_lag_ticks);
            end
            TRIG_RISING:  phase_next = PH_R0;
            TRIG_FALLING: phase_next = PH_F1;
            TRIG_PULSE:   phase_next = PH_P0A;
            default:      phase_next = PH_IDLE;
          endcase
        end
      end
      CMD_CLEAR: begin
        done_flag_next   = 1'b0;
        pulse_level_next = 1'b0;
        phase_next       = PH_IDLE;
        tick_count_next  = '0;
      end
      default: begin
        unique case (phase)
          PH_R0:  if (!lvl) phase_next = PH_R1;
          PH_F1:  if (lvl)  phase_next = PH_F0;
          PH_P0A: if (!lvl) phase_next = PH_P1;
          PH_P1:  if (lvl)  phase_next = PH_P0B;
          PH_R1, PH_F0, PH_P0B: begin
            if (lvl == (phase == PH_R1)) begin
              phase_next      = PH_DELAY;
              tick_count_next = CNT_W'(lag_ticks);
            end
          end
          PH_DELAY: begin
            if (tick_count == '0) begin
              phase_next       = PH_HIGH;
              tick_count_next  = CNT_W'(width_ticks) + CNT_W'(1);
              pulse_level_next = 1'b1;
            end else begin
              tick_count_next = tick_count - CNT_W'(1);
            end
          end
          PH_HIGH: begin
            if (tick_count == '0) begin
              pulse_level_next = 1'b0;
              done_flag_next   = 1'b1;
              phase_next       = PH_IDLE;
            end else begin
              tick_count_next = tick_count - CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= '0;
      lag_ticks   <= '0;
      width_ticks <= '0;
      done_flag   <= 1'b0;
      pulse_level <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      lag_ticks   <= lag_ticks_next;
      width_ticks <= width_ticks_next;
      done_flag   <= done_flag_next;
      pulse_level <= pulse_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.pulse_out      <= pulse_level_next;
      results.done_res       <= done_flag_next;
      results.busy_res       <= (phase_next != PH_IDLE);
      results.start_rejected <= rejected;
    end
  end

  assign results.valid = out_valid;

endmodule
`default_nettype wire
